>>> rtl/cfa_pkg.sv
// Shared request codes and controller/datapath interface types for the frame allocator.
`default_nettype none
package cfa_pkg;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;

	typedef struct packed {
		logic cap;
		logic scan_init;
		logic scan;
		logic mark;
		logic free_init;
		logic free;
		logic clr;
		logic res;
		logic res_fail;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       len_zero;
		logic       len_big;
		logic       free_skip;
		logic       scan_hit;
		logic       scan_miss;
		logic       mark_last;
		logic       free_last;
		logic       clr_last;
		logic       out_space;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/cfa_dp.sv
// Datapath of the frame allocator: occupancy map memory, scan counters, free count, result register.
`default_nettype none
module cfa_dp #(
	parameter int NUM_FRAMES = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfa_pkg::dp_cmd_t cmd,
	output cfa_pkg::dp_stat_t     stat,
	input  wire logic [1:0]       req_type,
	input  wire logic [5:0]       start_frame,
	input  wire logic [6:0]       run_length,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  status,
	output logic [5:0]            alloc_start,
	output logic [6:0]            free_frames
);
	import cfa_pkg::*;

	localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CW = $clog2(NUM_FRAMES + 1);
	localparam int SW = (CW > 8) ? CW : 8;
	localparam logic [CW-1:0] N_C = CW'(NUM_FRAMES);
	localparam logic [SW-1:0] N_S = SW'(NUM_FRAMES);

	logic          map_mem [NUM_FRAMES];
	logic          rd_data_q;

	logic [1:0]    type_q;
	logic [5:0]    first_q;
	logic [6:0]    len_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] end_q;
	logic [6:0]    run_q;
	logic          pend_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] free_cnt_q;
	logic          out_valid_q;
	logic          status_q;
	logic [CW-1:0] start_res_q;
	logic [CW-1:0] free_res_q;

	logic [SW-1:0] sum_s;
	logic [SW-1:0] hit_pos_s;
	logic [CW-1:0] free_end;
	logic [CW-1:0] hit_pos;
	logic [CW-1:0] idx_inc;
	logic [CW-1:0] idx_dec;
	logic          scan_hit;
	logic          rd_go;
	logic          wr_en;
	logic          wr_data;
	logic [AW-1:0] wr_addr;
	logic [CW+5:0] start_ext;
	logic [CW+6:0] free_ext;

	assign sum_s     = SW'(first_q) + SW'(len_q);
	assign free_end  = (sum_s < N_S) ? sum_s[CW-1:0] : N_C;
	assign hit_pos_s = SW'(idx_q) - SW'(len_q);
	assign hit_pos   = hit_pos_s[CW-1:0];
	assign idx_inc   = idx_q + CW'(1);
	assign idx_dec   = idx_q - CW'(1);

	// The registered read data belongs to the frame just before idx_q.
	assign scan_hit = pend_q && !rd_data_q && ((run_q + 7'd1) == len_q);

	assign rd_go = (cmd.scan && (idx_q < N_C)) || (cmd.free && (idx_q < end_q));

	always_comb begin
		wr_en   = 1'b0;
		wr_data = 1'b0;
		wr_addr = idx_q[AW-1:0];
		if (cmd.mark) begin
			wr_en   = 1'b1;
			wr_data = 1'b1;
		end else if (cmd.free && pend_q) begin
			wr_en   = 1'b1;
			wr_addr = idx_dec[AW-1:0];
		end else if (cmd.clr) begin
			wr_en   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_go) begin
			rd_data_q <= map_mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pend_q      <= 1'b0;
			free_cnt_q  <= N_C;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_init) begin
				idx_q  <= '0;
				pend_q <= 1'b0;
			end else if (cmd.free_init) begin
				idx_q  <= CW'(first_q);
				pend_q <= 1'b0;
			end else if (cmd.scan) begin
				if (scan_hit) begin
					idx_q  <= hit_pos;
					pend_q <= 1'b0;
				end else begin
					if (idx_q < N_C) begin
						idx_q <= idx_inc;
					end
					pend_q <= (idx_q < N_C);
				end
			end else if (cmd.free) begin
				if (idx_q < end_q) begin
					idx_q <= idx_inc;
				end
				pend_q <= (idx_q < end_q);
			end else if (cmd.mark || cmd.clr) begin
				idx_q <= idx_inc;
			end

			if (cmd.mark) begin
				free_cnt_q <= free_cnt_q - CW'(1);
			end else if (cmd.free && pend_q && rd_data_q) begin
				free_cnt_q <= free_cnt_q + CW'(1);
			end

			if (cmd.res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			type_q  <= req_type;
			first_q <= start_frame;
			len_q   <= run_length;
			pos_q   <= '0;
		end
		if (cmd.scan_init) begin
			run_q <= '0;
		end else if (cmd.scan && pend_q) begin
			run_q <= rd_data_q ? 7'd0 : (run_q + 7'd1);
		end
		if (cmd.scan && scan_hit) begin
			pos_q <= hit_pos;
			end_q <= idx_q;
		end else if (cmd.free_init) begin
			end_q <= free_end;
		end
		if (cmd.res) begin
			status_q    <= cmd.res_fail;
			start_res_q <= pos_q;
			free_res_q  <= free_cnt_q;
		end
	end

	assign stat.req_type  = type_q;
	assign stat.len_zero  = (len_q == 7'd0);
	assign stat.len_big   = (SW'(len_q) > N_S);
	assign stat.free_skip = (len_q == 7'd0) || (SW'(first_q) >= N_S);
	assign stat.scan_hit  = scan_hit;
	assign stat.scan_miss = pend_q && !scan_hit && (idx_q == N_C);
	assign stat.mark_last = (idx_inc == end_q);
	assign stat.free_last = pend_q && (idx_q == end_q);
	assign stat.clr_last  = (idx_q == (N_C - CW'(1)));
	assign stat.out_space = !out_valid_q || out_ready;

	assign start_ext   = {6'd0, start_res_q};
	assign free_ext    = {7'd0, free_res_q};
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign alloc_start = start_ext[5:0];
	assign free_frames = free_ext[6:0];

endmodule
`default_nettype wire

>>> rtl/cfa_ctrl.sv
// Controller state machine of the frame allocator: sequences clearing, scan, marking and freeing.
`default_nettype none
module cfa_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output cfa_pkg::dp_cmd_t      cmd,
	input  wire cfa_pkg::dp_stat_t stat
);
	import cfa_pkg::*;

	localparam logic [2:0] ST_CLR    = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_MARK   = 3'd4;
	localparam logic [2:0] ST_FREE   = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       fail_q;
	logic       fail_nx;

	always_comb begin
		state_nx = state_q;
		fail_nx  = fail_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap  = 1'b1;
					fail_nx  = 1'b0;
					state_nx = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_nx = ST_DONE;
				if (stat.req_type == REQ_ALLOC) begin
					if (stat.len_big) begin
						fail_nx = 1'b1;
					end else if (!stat.len_zero) begin
						cmd.scan_init = 1'b1;
						state_nx      = ST_SCAN;
					end
				end else if (stat.req_type == REQ_FREE) begin
					if (!stat.free_skip) begin
						cmd.free_init = 1'b1;
						state_nx      = ST_FREE;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_hit) begin
					state_nx = ST_MARK;
				end else if (stat.scan_miss) begin
					fail_nx  = 1'b1;
					state_nx = ST_DONE;
				end
			end
			ST_MARK: begin
				cmd.mark = 1'b1;
				if (stat.mark_last) begin
					state_nx = ST_DONE;
				end
			end
			ST_FREE: begin
				cmd.free = 1'b1;
				if (stat.free_last) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.res_fail = fail_q;
				if (stat.out_space) begin
					cmd.res  = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			fail_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			fail_q  <= fail_nx;
		end
	end

endmodule
`default_nettype wire

>>> rtl/contiguous_frame_allocator_core.sv
// First-fit contiguous frame allocator over a one-bit-per-frame occupancy map.
//
// Requests enter on the in_* channel (req_type, start_frame, run_length) and each one
// yields exactly one result transaction on the out_* channel (status, alloc_start,
// free_frames). Request code 0 allocates a run, 1 frees a run, anything else queries.
// After reset the block clears the occupancy map one frame per cycle; in_ready stays
// low until that pass is finished. One request is worked on at a time. A query, a
// zero-length request or a free that starts past the end goes straight to the result
// register; a free walks its run and clears each frame; an allocation scans the map
// one frame per cycle through the single read port of the map memory and then marks
// its run one frame per cycle. The result sits in an output register; a new request
// is accepted while it waits. If the receiver stalls, the next finished result is held
// back until the register frees up, and the block takes no further request meanwhile.
`default_nettype none
module contiguous_frame_allocator_core #(
	parameter int NUM_FRAMES = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] req_type,
	input  wire logic [5:0] start_frame,
	input  wire logic [6:0] run_length,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            status,
	output logic [5:0]      alloc_start,
	output logic [6:0]      free_frames
);
	import cfa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	cfa_dp #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (req_type),
		.start_frame (start_frame),
		.run_length  (run_length),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.alloc_start (alloc_start),
		.free_frames (free_frames)
	);

	// Only one request is in flight, so acceptance closes the input for the next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a request was in flight");

	a_fail_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> alloc_start == 6'd0)
		else $error("failed allocation reports a nonzero start frame");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(free_frames) <= NUM_FRAMES)
		else $error("free frame count above the number of frames");

	a_no_cmd_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.mark && !cmd.free && !cmd.scan)
		else $error("map update while waiting for a request");

endmodule
`default_nettype wire
